// ===== hdl/assert_macros.svh =====
// assertion macros shared by the checker file
// depends on nothing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that must hold in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("assertion failed");
// property that holds at every edge
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`endif

// ===== hdl/tcn_pkg.sv =====
// package for the triangle centroid and normal block
// holds the widths, depends on nothing
package tcn_pkg;
   localparam int COORD_WIDTH_DEF = 16;
   localparam int NORMAL_FRAC_DEF = 14;
   localparam int NORMAL_WIDTH    = 16;
   localparam int KEEP_BITS       = 30;
   localparam int SQ_WIDTH        = 64;
   localparam int ROOT_WIDTH      = 32;
endpackage

// ===== hdl/tcn_sqrt_cell.sv =====
// one digit cell of the pipelined integer square root
// uses tcn_pkg, one result bit per cell, passes data to the next cell
module tcn_sqrt_cell
   import tcn_pkg::*;
#(
   parameter int STEP = 0,
   parameter int SIDE_WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  valid_in,
   input  logic [SQ_WIDTH-1:0]   rem_in,
   input  logic [ROOT_WIDTH-1:0] root_in,
   input  logic [SIDE_WIDTH-1:0] side_in,
   output logic                  valid_out,
   output logic [SQ_WIDTH-1:0]   rem_out,
   output logic [ROOT_WIDTH-1:0] root_out,
   output logic [SIDE_WIDTH-1:0] side_out
);
   localparam int SH = 2 * (ROOT_WIDTH - 1 - STEP);
   logic                  valid_ff;
   logic [SQ_WIDTH-1:0]   rem_ff, rem_in_c;
   logic [ROOT_WIDTH-1:0] root_ff, root_in_c;
   logic [SIDE_WIDTH-1:0] side_ff;
   logic [SQ_WIDTH+1:0]   trial;

   // compare remainder against (4*root+1) << shift
   always_comb begin
      trial = (SQ_WIDTH+2)'({root_in, 2'b01}) << SH;
      if ({2'b00, rem_in} >= trial) begin
         rem_in_c  = rem_in - trial[SQ_WIDTH-1:0];
         root_in_c = {root_in[ROOT_WIDTH-2:0], 1'b1};
      end else begin
         rem_in_c  = rem_in;
         root_in_c = {root_in[ROOT_WIDTH-2:0], 1'b0};
      end
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rem_ff  <= rem_in_c;
      root_ff <= root_in_c;
      side_ff <= side_in;
   end

   assign valid_out = valid_ff;
   assign rem_out   = rem_ff;
   assign root_out  = root_ff;
   assign side_out  = side_ff;
endmodule

// ===== hdl/tcn_div_cell.sv =====
// one quotient bit cell of the pipelined restoring divider
// uses tcn_pkg, three lanes share the divisor, data passes to the next cell
module tcn_div_cell
   import tcn_pkg::*;
#(
   parameter int NUM_WIDTH = 46,
   parameter int SIDE_WIDTH = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      valid_in,
   input  logic [ROOT_WIDTH-1:0]     den_in,
   input  logic [3*NUM_WIDTH-1:0]    num_in,
   input  logic [3*(ROOT_WIDTH+1)-1:0] rem_in,
   input  logic [SIDE_WIDTH-1:0]     side_in,
   output logic                      valid_out,
   output logic [ROOT_WIDTH-1:0]     den_out,
   output logic [3*NUM_WIDTH-1:0]    num_out,
   output logic [3*(ROOT_WIDTH+1)-1:0] rem_out,
   output logic [SIDE_WIDTH-1:0]     side_out
);
   localparam int RW = ROOT_WIDTH + 1;
   logic                  valid_ff;
   logic [ROOT_WIDTH-1:0] den_ff;
   logic [3*NUM_WIDTH-1:0] num_ff, num_nx;
   logic [3*RW-1:0]       rem_ff, rem_nx;
   logic [SIDE_WIDTH-1:0] side_ff;
   logic [RW:0]           shifted;

   // shift in the next numerator bit and subtract where it fits
   always_comb begin
      num_nx = '0;
      rem_nx = '0;
      shifted = '0;
      for (int k = 0; k < 3; k++) begin
         shifted = {rem_in[k*RW +: RW], num_in[k*NUM_WIDTH + NUM_WIDTH - 1]};
         num_nx[k*NUM_WIDTH +: NUM_WIDTH] = {num_in[k*NUM_WIDTH +: NUM_WIDTH-1], 1'b0};
         if (shifted >= {2'b00, den_in}) begin
            rem_nx[k*RW +: RW] = RW'(shifted - {2'b00, den_in});
            num_nx[k*NUM_WIDTH] = 1'b1;
         end else begin
            rem_nx[k*RW +: RW] = shifted[RW-1:0];
         end
      end
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      den_ff  <= den_in;
      num_ff  <= num_nx;
      rem_ff  <= rem_nx;
      side_ff <= side_in;
   end

   assign valid_out = valid_ff;
   assign den_out   = den_ff;
   assign num_out   = num_ff;
   assign rem_out   = rem_ff;
   assign side_out  = side_ff;
endmodule

// ===== hdl/triangle_centroid_and_unit_normal.sv =====
// triangle centroid and unit face normal, top level
// pipeline at the defaults from the transfer edge to the edge that takes the
// result: 7 front stages, 32 square root cells, 1 numerator stage, NUM_WIDTH divider cells, 1 output
// throughput one triangle per cycle: every cell is a pipeline stage, busy is always low
// reset clears only the valid bits of the stages; results in flight are dropped, none are invented
// uses tcn_pkg, tcn_sqrt_cell and tcn_div_cell
module triangle_centroid_and_unit_normal
   import tcn_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_a_x,
   input  logic signed [COORD_WIDTH-1:0] req_a_y,
   input  logic signed [COORD_WIDTH-1:0] req_a_z,
   input  logic signed [COORD_WIDTH-1:0] req_b_x,
   input  logic signed [COORD_WIDTH-1:0] req_b_y,
   input  logic signed [COORD_WIDTH-1:0] req_b_z,
   input  logic signed [COORD_WIDTH-1:0] req_c_x,
   input  logic signed [COORD_WIDTH-1:0] req_c_y,
   input  logic signed [COORD_WIDTH-1:0] req_c_z,
   output logic                          rsp_valid,
   output logic signed [COORD_WIDTH-1:0] rsp_centroid_x,
   output logic signed [COORD_WIDTH-1:0] rsp_centroid_y,
   output logic signed [COORD_WIDTH-1:0] rsp_centroid_z,
   output logic signed [NORMAL_WIDTH-1:0] rsp_normal_x,
   output logic signed [NORMAL_WIDTH-1:0] rsp_normal_y,
   output logic signed [NORMAL_WIDTH-1:0] rsp_normal_z,
   output logic                          rsp_degenerate
);
   localparam int DW = COORD_WIDTH + 1;          // difference width
   localparam int PW = 2 * DW;                   // product magnitude width
   localparam int CW = PW + 1;                   // cross magnitude width
   localparam int LW = $clog2(CW + 1);           // bit length width
   localparam int SW = COORD_WIDTH + 2;          // sum width
   localparam int NUM_WIDTH = KEEP_BITS + NORMAL_FRAC_BITS + 1;
   localparam int SIDE_WIDTH = 3 * COORD_WIDTH + 4;
   localparam int RW = ROOT_WIDTH + 1;
   localparam int QW = SW + SW;                   // reciprocal product width
   // ceil(2^SW / 3), exact for sums below 2^(SW-1)
   localparam logic [SW-1:0] RECIP3 = SW'(((64'd1 << SW) + 64'd2) / 64'd3);

   assign busy = 1'b0;

   // stage 1: differences and sums
   logic                 s1_v_ff;
   logic signed [DW-1:0] ux_ff, uy_ff, uz_ff, wx_ff, wy_ff, wz_ff;
   logic signed [SW-1:0] sum_ff [3];
   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else s1_v_ff <= start;
      ux_ff <= DW'(req_b_x) - DW'(req_a_x);
      uy_ff <= DW'(req_b_y) - DW'(req_a_y);
      uz_ff <= DW'(req_b_z) - DW'(req_a_z);
      wx_ff <= DW'(req_c_x) - DW'(req_a_x);
      wy_ff <= DW'(req_c_y) - DW'(req_a_y);
      wz_ff <= DW'(req_c_z) - DW'(req_a_z);
      sum_ff[0] <= SW'(req_a_x) + SW'(req_b_x) + SW'(req_c_x);
      sum_ff[1] <= SW'(req_a_y) + SW'(req_b_y) + SW'(req_c_y);
      sum_ff[2] <= SW'(req_a_z) + SW'(req_b_z) + SW'(req_c_z);
   end

   // stage 2: six signed products, centroid by reciprocal multiply
   logic                 s2_v_ff;
   logic signed [PW-1:0] p_ff [6];
   logic signed [COORD_WIDTH-1:0] cen2_ff [3];
   logic [SW-1:0]        sabs [3];
   logic [QW-1:0]        qprod [3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sabs[k]  = sum_ff[k][SW-1] ? SW'(-sum_ff[k]) : SW'(sum_ff[k]);
         qprod[k] = QW'(sabs[k]) * QW'(RECIP3);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else s2_v_ff <= s1_v_ff;
      p_ff[0] <= PW'(uy_ff) * PW'(wz_ff);
      p_ff[1] <= PW'(uz_ff) * PW'(wy_ff);
      p_ff[2] <= PW'(uz_ff) * PW'(wx_ff);
      p_ff[3] <= PW'(ux_ff) * PW'(wz_ff);
      p_ff[4] <= PW'(ux_ff) * PW'(wy_ff);
      p_ff[5] <= PW'(uy_ff) * PW'(wx_ff);
      for (int k = 0; k < 3; k++) begin
         cen2_ff[k] <= sum_ff[k][SW-1] ? -COORD_WIDTH'(qprod[k][QW-1:SW])
                                       : COORD_WIDTH'(qprod[k][QW-1:SW]);
      end
   end

   // stage 3: cross components, sign and magnitude
   logic                 s3_v_ff;
   logic [2:0]           neg_ff;
   logic [CW-1:0]        mag_ff [3];
   logic signed [CW-1:0] cr [3];
   logic signed [COORD_WIDTH-1:0] cen3_ff [3];
   always_comb begin
      cr[0] = CW'(p_ff[0]) - CW'(p_ff[1]);
      cr[1] = CW'(p_ff[2]) - CW'(p_ff[3]);
      cr[2] = CW'(p_ff[4]) - CW'(p_ff[5]);
   end
   always_ff @(posedge clock) begin
      if (reset) s3_v_ff <= 1'b0;
      else s3_v_ff <= s2_v_ff;
      for (int k = 0; k < 3; k++) begin
         neg_ff[k]  <= cr[k][CW-1];
         mag_ff[k]  <= cr[k][CW-1] ? CW'(-cr[k]) : CW'(cr[k]);
         cen3_ff[k] <= cen2_ff[k];
      end
   end

   // stage 4: bit length of the largest magnitude
   logic                 s4_v_ff;
   logic [CW-1:0]        or_mag;
   logic [LW-1:0]        len_c, len_ff;
   logic [2:0]           neg4_ff;
   logic [CW-1:0]        mag4_ff [3];
   logic signed [COORD_WIDTH-1:0] cen4_ff [3];
   always_comb begin
      or_mag = mag_ff[0] | mag_ff[1] | mag_ff[2];
      len_c = '0;
      for (int b = 0; b < CW; b++) begin
         if (or_mag[b]) len_c = LW'(b + 1);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) s4_v_ff <= 1'b0;
      else s4_v_ff <= s3_v_ff;
      len_ff  <= len_c;
      neg4_ff <= neg_ff;
      mag4_ff <= mag_ff;
      cen4_ff <= cen3_ff;
   end

   // stage 5: shift down to at most the kept bits
   logic                 s5_v_ff;
   logic                 deg5_ff;
   logic [2:0]           neg5_ff;
   logic [KEEP_BITS-1:0] m5_ff [3];
   logic [LW-1:0]        sh;
   logic signed [COORD_WIDTH-1:0] cen5_ff [3];
   always_comb begin
      sh = (len_ff > LW'(KEEP_BITS)) ? LW'(len_ff - LW'(KEEP_BITS)) : '0;
   end
   always_ff @(posedge clock) begin
      if (reset) s5_v_ff <= 1'b0;
      else s5_v_ff <= s4_v_ff;
      deg5_ff <= (len_ff == '0);
      neg5_ff <= neg4_ff;
      for (int k = 0; k < 3; k++) m5_ff[k] <= KEEP_BITS'(mag4_ff[k] >> sh);
      cen5_ff <= cen4_ff;
   end

   // stage 6: squares
   logic                 s6_v_ff;
   logic [2*KEEP_BITS-1:0] sq6_ff [3];
   logic [KEEP_BITS-1:0] m6_ff [3];
   logic                 deg6_ff;
   logic [2:0]           neg6_ff;
   logic signed [COORD_WIDTH-1:0] cen6_ff [3];
   always_ff @(posedge clock) begin
      if (reset) s6_v_ff <= 1'b0;
      else s6_v_ff <= s5_v_ff;
      for (int k = 0; k < 3; k++) sq6_ff[k] <= (2*KEEP_BITS)'(m5_ff[k]) * (2*KEEP_BITS)'(m5_ff[k]);
      m6_ff <= m5_ff;
      deg6_ff <= deg5_ff;
      neg6_ff <= neg5_ff;
      cen6_ff <= cen5_ff;
   end

   // stage 7: sum of squares
   logic                 s7_v_ff;
   logic [SQ_WIDTH-1:0]  ss7_ff;
   logic [KEEP_BITS-1:0] m7_ff [3];
   logic                 deg7_ff;
   logic [2:0]           neg7_ff;
   logic signed [COORD_WIDTH-1:0] cen7_ff [3];
   always_ff @(posedge clock) begin
      if (reset) s7_v_ff <= 1'b0;
      else s7_v_ff <= s6_v_ff;
      ss7_ff <= SQ_WIDTH'(sq6_ff[0]) + SQ_WIDTH'(sq6_ff[1]) + SQ_WIDTH'(sq6_ff[2]);
      m7_ff <= m6_ff;
      deg7_ff <= deg6_ff;
      neg7_ff <= neg6_ff;
      cen7_ff <= cen6_ff;
   end

   // side data that rides along the root chain: magnitudes are kept in a
   // delay line of their own, the chains carry only flags and centroid
   logic [SIDE_WIDTH-1:0] side7;
   assign side7 = {deg7_ff, neg7_ff, cen7_ff[0], cen7_ff[1], cen7_ff[2]};

   // square root chain, one bit per cell
   logic                  rv [ROOT_WIDTH+1];
   logic [SQ_WIDTH-1:0]   rrem [ROOT_WIDTH+1];
   logic [ROOT_WIDTH-1:0] rroot [ROOT_WIDTH+1];
   logic [SIDE_WIDTH-1:0] rside [ROOT_WIDTH+1];
   assign rv[0]    = s7_v_ff;
   assign rrem[0]  = ss7_ff;
   assign rroot[0] = '0;
   assign rside[0] = side7;
   for (genvar g = 0; g < ROOT_WIDTH; g++) begin : g_root
      tcn_sqrt_cell #(.STEP(g), .SIDE_WIDTH(SIDE_WIDTH)) u_cell (
         .clock(clock), .reset(reset),
         .valid_in(rv[g]), .rem_in(rrem[g]), .root_in(rroot[g]), .side_in(rside[g]),
         .valid_out(rv[g+1]), .rem_out(rrem[g+1]), .root_out(rroot[g+1]),
         .side_out(rside[g+1])
      );
   end

   // magnitudes delay line across the root chain
   logic [3*KEEP_BITS-1:0] mdly_ff [ROOT_WIDTH];
   always_ff @(posedge clock) begin
      mdly_ff[0] <= {m7_ff[0], m7_ff[1], m7_ff[2]};
      for (int k = 1; k < ROOT_WIDTH; k++) mdly_ff[k] <= mdly_ff[k-1];
   end

   // numerators: m << frac + r/2, divisor r (forced to at least 1)
   logic                   d0_v_ff;
   logic [ROOT_WIDTH-1:0]  den0_ff;
   logic [3*NUM_WIDTH-1:0] num0_ff;
   logic [SIDE_WIDTH-1:0]  dside0_ff;
   logic [ROOT_WIDTH-1:0]  rootf;
   assign rootf = (rroot[ROOT_WIDTH] == '0) ? ROOT_WIDTH'(1) : rroot[ROOT_WIDTH];
   always_ff @(posedge clock) begin
      if (reset) d0_v_ff <= 1'b0;
      else d0_v_ff <= rv[ROOT_WIDTH];
      den0_ff <= rootf;
      for (int k = 0; k < 3; k++) begin
         num0_ff[(2-k)*NUM_WIDTH +: NUM_WIDTH] <=
            (NUM_WIDTH'(mdly_ff[ROOT_WIDTH-1][(2-k)*KEEP_BITS +: KEEP_BITS]) << NORMAL_FRAC_BITS)
            + NUM_WIDTH'(rootf >> 1);
      end
      dside0_ff <= rside[ROOT_WIDTH];
   end

   // divider chain, one quotient bit per cell, three lanes
   logic                   dv [NUM_WIDTH+1];
   logic [ROOT_WIDTH-1:0]  dden [NUM_WIDTH+1];
   logic [3*NUM_WIDTH-1:0] dnum [NUM_WIDTH+1];
   logic [3*RW-1:0]        drem [NUM_WIDTH+1];
   logic [SIDE_WIDTH-1:0]  dside [NUM_WIDTH+1];
   assign dv[0] = d0_v_ff;
   assign dden[0] = den0_ff;
   assign dnum[0] = num0_ff;
   assign drem[0] = '0;
   assign dside[0] = dside0_ff;
   for (genvar g = 0; g < NUM_WIDTH; g++) begin : g_div
      tcn_div_cell #(.NUM_WIDTH(NUM_WIDTH), .SIDE_WIDTH(SIDE_WIDTH)) u_cell (
         .clock(clock), .reset(reset),
         .valid_in(dv[g]), .den_in(dden[g]), .num_in(dnum[g]), .rem_in(drem[g]),
         .side_in(dside[g]),
         .valid_out(dv[g+1]), .den_out(dden[g+1]), .num_out(dnum[g+1]),
         .rem_out(drem[g+1]), .side_out(dside[g+1])
      );
   end

   // output register with sign, saturation and a zero normal for degenerate triangles
   logic                   o_v_ff;
   logic signed [NORMAL_WIDTH-1:0] nrm_ff [3];
   logic signed [COORD_WIDTH-1:0]  ocen_ff [3];
   logic                   odeg_ff;
   logic [SIDE_WIDTH-1:0]  fs;
   logic [NUM_WIDTH-1:0]   qv [3];
   logic signed [NORMAL_WIDTH-1:0] nv [3];
   localparam logic [NUM_WIDTH-1:0] LIM_POS = NUM_WIDTH'((1 << (NORMAL_WIDTH-1)) - 1);
   localparam logic [NUM_WIDTH-1:0] LIM_NEG = NUM_WIDTH'(1 << (NORMAL_WIDTH-1));
   always_comb begin
      fs = dside[NUM_WIDTH];
      for (int k = 0; k < 3; k++) begin
         qv[k] = dnum[NUM_WIDTH][(2-k)*NUM_WIDTH +: NUM_WIDTH];
         if (fs[SIDE_WIDTH-1]) begin
            nv[k] = '0;
         end else if (fs[3*COORD_WIDTH + k]) begin
            nv[k] = (qv[k] > LIM_NEG) ? -NORMAL_WIDTH'(LIM_NEG)
                                      : -NORMAL_WIDTH'(qv[k]);
         end else begin
            nv[k] = (qv[k] > LIM_POS) ? NORMAL_WIDTH'(LIM_POS) : NORMAL_WIDTH'(qv[k]);
         end
      end
   end
   always_ff @(posedge clock) begin
      if (reset) o_v_ff <= 1'b0;
      else o_v_ff <= dv[NUM_WIDTH];
      nrm_ff <= nv;
      odeg_ff <= fs[SIDE_WIDTH-1];
      ocen_ff[0] <= fs[3*COORD_WIDTH-1 -: COORD_WIDTH];
      ocen_ff[1] <= fs[2*COORD_WIDTH-1 -: COORD_WIDTH];
      ocen_ff[2] <= fs[COORD_WIDTH-1 -: COORD_WIDTH];
   end

   assign rsp_valid      = o_v_ff;
   assign rsp_centroid_x = ocen_ff[0];
   assign rsp_centroid_y = ocen_ff[1];
   assign rsp_centroid_z = ocen_ff[2];
   assign rsp_normal_x   = nrm_ff[0];
   assign rsp_normal_y   = nrm_ff[1];
   assign rsp_normal_z   = nrm_ff[2];
   assign rsp_degenerate = odeg_ff;
endmodule

// ===== hdl/tcn_checker.sv =====
// port level checks for the triangle centroid and normal block
// uses assert_macros.svh, bound to the top level
`include "assert_macros.svh"
module tcn_checker (
   input logic        clock,
   input logic        reset,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_degenerate,
   input logic [15:0] rsp_normal_x,
   input logic [15:0] rsp_normal_y,
   input logic [15:0] rsp_normal_z
);
   logic normal_zero;
   assign normal_zero = (rsp_normal_x == 16'd0) && (rsp_normal_y == 16'd0)
                        && (rsp_normal_z == 16'd0);

   // the block never stalls the sender
   `ASSERT_ALWAYS(a_never_busy, clock, reset, !busy)
   // a degenerate result carries a zero normal
   `ASSERT_ALWAYS(a_deg_zero, clock, reset, !(rsp_valid && rsp_degenerate) || normal_zero)
   // no result right after reset
   `ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)
endmodule

bind triangle_centroid_and_unit_normal tcn_checker u_tcn_checker (
   .clock(clock), .reset(reset), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_degenerate(rsp_degenerate), .rsp_normal_x(rsp_normal_x),
   .rsp_normal_y(rsp_normal_y), .rsp_normal_z(rsp_normal_z)
);
